### sv/kmdd_pkg.sv
// Shared types, constants and the key decode table of the key matrix debounce unit.
// No dependencies; every other file of the unit imports this package.
package kmdd_pkg;

    localparam int KEY_COUNT  = 16;
    localparam int STAMP_BITS = 32;
    localparam int INDEX_BITS = $clog2(KEY_COUNT);

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [STAMP_BITS-1:0] STAMP_IDLE = {STAMP_BITS{1'b1}};

    // Decoded key values.
    localparam logic [3:0] VALUE_DIGIT_MAX = 4'd9;
    localparam logic [3:0] VALUE_POINT     = 4'd10;
    localparam logic [3:0] VALUE_NONE      = 4'd11;

    // Key index (column*4+row) to decoded value.
    localparam logic [3:0] KEY_MAP [0:KEY_COUNT-1] = '{
        4'd1, 4'd4, 4'd7, VALUE_NONE,
        4'd2, 4'd5, 4'd8, 4'd0,
        4'd3, 4'd6, 4'd9, VALUE_POINT,
        VALUE_NONE, VALUE_NONE, VALUE_NONE, VALUE_NONE
    };

    typedef struct packed {
        logic [15:0] key_levels;
        logic [31:0] now_ms;
    } t_key_in;

    typedef struct packed {
        logic [15:0] press_pulses;
        logic [15:0] release_pulses;
        logic        key_seen;
        logic [3:0]  key_index;
        logic [3:0]  key_value;
        logic        digit_flag;
    } t_key_out;

endpackage

### sv/kmdd_lane.sv
// One key lane: edge detection, press and release debounce timers for a single key.
// Depends on kmdd_pkg for the stamp width and the idle stamp value.
module kmdd_lane
    import kmdd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_level,
    input  logic [STAMP_BITS-1:0] i_now,
    input  logic [15:0]           i_debounce_ms,
    output logic                  o_press,
    output logic                  o_release
);

    logic                  r_prev, n_prev;
    logic                  r_press_armed, n_press_armed;
    logic                  r_release_armed, n_release_armed;
    logic [STAMP_BITS-1:0] r_press_start, n_press_start;
    logic [STAMP_BITS-1:0] r_release_start, n_release_start;

    logic                  rise, fall;
    logic                  press_run, release_run;
    logic [STAMP_BITS-1:0] press_from, release_from;
    logic [STAMP_BITS-1:0] press_elapsed, release_elapsed;
    logic                  press_done, release_done;
    logic [STAMP_BITS-1:0] limit;

    always_comb begin
        limit       = STAMP_BITS'(i_debounce_ms);
        rise        = i_level & ~r_prev;
        fall        = ~i_level & r_prev;

        // A timer armed by an edge in this scan is tested in the same scan.
        press_run   = rise | r_press_armed;
        press_from  = rise ? i_now : r_press_start;
        press_elapsed = i_now - press_from;
        press_done  = press_run & (press_elapsed >= limit);

        release_run   = fall | r_release_armed;
        release_from  = fall ? i_now : r_release_start;
        release_elapsed = i_now - release_from;
        release_done  = release_run & (release_elapsed >= limit);

        o_press   = press_done & i_level;
        o_release = release_done & ~i_level;

        n_prev          = i_level;
        n_press_armed   = press_run & ~press_done;
        n_release_armed = release_run & ~release_done;
        n_press_start   = press_done ? STAMP_IDLE : press_from;
        n_release_start = release_done ? STAMP_IDLE : release_from;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev          <= 1'b0;
            r_press_armed   <= 1'b0;
            r_release_armed <= 1'b0;
        end else if (i_accept) begin
            r_prev          <= n_prev;
            r_press_armed   <= n_press_armed;
            r_release_armed <= n_release_armed;
        end
    end

    // Start stamps are only read while armed, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_press_start   <= n_press_start;
            r_release_start <= n_release_start;
        end
    end

endmodule

### sv/kmdd_merge.sv
// Merging stage: combines the lane pulses, picks the highest pressed key and decodes it.
// Depends on kmdd_pkg for the result type and the decode table.
module kmdd_merge
    import kmdd_pkg::*;
(
    input  logic [KEY_COUNT-1:0] i_press,
    input  logic [KEY_COUNT-1:0] i_release,
    output t_key_out             o_result
);

    logic [INDEX_BITS-1:0] idx;
    logic                  seen;
    logic [3:0]            value;

    always_comb begin
        idx  = '0;
        seen = |i_press;
        // Later lanes override earlier ones, so the highest index wins.
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (i_press[k]) begin
                idx = INDEX_BITS'(k);
            end
        end
        value = seen ? KEY_MAP[idx] : VALUE_NONE;

        o_result.press_pulses   = i_press;
        o_result.release_pulses = i_release;
        o_result.key_seen       = seen;
        o_result.key_index      = 4'(idx);
        o_result.key_value      = value;
        o_result.digit_flag     = (value <= VALUE_DIGIT_MAX);
    end

endmodule

### sv/keypad_matrix_debounce_decode_unit.sv
// Top level of the key matrix debounce and decode unit: sixteen key lanes, the merging
// stage and a two-deep output buffer. Depends on kmdd_pkg, kmdd_lane and kmdd_merge.
//
// Each input item is one complete scan of a 4x4 key matrix (sixteen levels, 1 meaning
// pressed, plus a millisecond time stamp) and yields exactly one result item. Every key
// has its own lane with a press timer, armed on a rising level, and a release timer, armed
// on a falling level; a fresh edge restarts its timer. Once a timer has run for at least
// debounce_ms milliseconds it disarms, and if the key still shows the new level a pulse is
// given for that key in that scan's result. Elapsed time is taken modulo 2^32, so stamp
// wraparound is harmless, while a stamp that steps backwards reads as a very long time.
// With debounce_ms set to zero the pulse comes in the scan of the edge itself. The highest
// key with a press pulse is decoded to a digit, the point (value 10) or none (value 11).
// The unit takes one scan every clock cycle while the input is not stalled: all lanes
// update in the cycle an item is accepted, and the result is registered, in the output
// entry or, while that is held, in the skid entry. A two-entry output buffer lets a new
// item in while a finished result still waits, and the input is stalled only once both
// entries are full. debounce_ms resets to 50 and is written over the configuration
// channel, which is always ready; it should be changed only while the unit is idle.
module keypad_matrix_debounce_decode_unit
    import kmdd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Scan items in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_key_in     i_in_item,
    // Result items out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_key_out    o_out_item,
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]          r_debounce_ms;
    logic                 r_out_valid, n_out_valid;
    logic                 r_skid_valid, n_skid_valid;
    t_key_out             r_out_item, n_out_item;
    t_key_out             r_skid_item, n_skid_item;

    logic                 in_accept;
    logic                 out_take;
    logic [KEY_COUNT-1:0] lane_press;
    logic [KEY_COUNT-1:0] lane_release;
    t_key_out             merged;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid & ~r_skid_valid;
    assign out_take    = r_out_valid & ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce_ms <= i_cfg_data;
        end
    end

    // One lane per key; all lanes see the same time stamp.
    for (genvar g = 0; g < KEY_COUNT; g++) begin : g_lane
        kmdd_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_accept      (in_accept),
            .i_level       (i_in_item.key_levels[g]),
            .i_now         (i_in_item.now_ms[STAMP_BITS-1:0]),
            .i_debounce_ms (r_debounce_ms),
            .o_press       (lane_press[g]),
            .o_release     (lane_release[g])
        );
    end

    kmdd_merge u_merge (
        .i_press   (lane_press),
        .i_release (lane_release),
        .o_result  (merged)
    );

    // Output buffer: the skid entry only fills while the output entry is held, and it
    // drains into the output entry before any new item is accepted.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_item   = r_out_item;
        n_skid_item  = r_skid_item;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end else if (in_accept) begin
                n_out_valid = 1'b1;
                n_out_item  = merged;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_accept) begin
            n_skid_valid = 1'b1;
            n_skid_item  = merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    // The skid entry is never occupied while the output entry is empty.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the output entry is empty");

    // A result that is accepted while the output is held lands in the skid entry.
    a_held_accept_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("item accepted under a held output was lost");

    // key_seen must agree with the press pulses it summarises.
    a_seen_matches_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.key_seen == (r_out_item.press_pulses != '0)))
        else $error("key_seen disagrees with press_pulses");

    // A digit can only be reported for a scan that saw a press.
    a_digit_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.digit_flag) |-> r_out_item.key_seen)
        else $error("digit reported without a press pulse");

endmodule
